[sv/gdr_pkg.sv]
`default_nettype none
package gdr_pkg;

	localparam int MAP_SIZE       = 64;
	localparam int SCREEN_HEIGHT  = 480;
	localparam int SCREEN_COLUMNS = 512;
	localparam int MAX_STEPS      = 128;

	localparam int CELL_W    = 6;
	localparam int MAP_AW    = 2 * CELL_W;
	localparam int MAP_CELLS = MAP_SIZE * MAP_SIZE;
	localparam int POS_W     = CELL_W + 2;
	localparam int COL_W     = 9;
	localparam int COL_SHIFT = $clog2(SCREEN_COLUMNS);
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_W    = 10;
	localparam int RAY_W     = 20;
	localparam int PROD_W    = 33;
	localparam int DIST_W    = 24;
	localparam int SD_W      = 32;
	localparam int LH_W      = 16;
	localparam int ROW_W     = 9;
	localparam int STEP_W    = $clog2(MAX_STEPS + 1);
	localparam int DIV_NW    = 25;
	localparam int DIV_DW    = 24;
	localparam int DIV_CW    = $clog2(DIV_NW);

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [LH_W-1:0]   LH_MAX   = {LH_W{1'b1}};

	localparam logic OPC_MAP_WRITE = 1'b0;
	localparam logic OPC_CAST      = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PLAYER_X, CFG_PLAYER_Y, CFG_DIR_X, CFG_DIR_Y, CFG_PLANE_X, CFG_PLANE_Y
	} cfg_idx_t;

	typedef struct packed {
		logic             opcode;
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic             cell_is_wall;
		logic [COL_W-1:0]  screen_column;
	} in_item_t;

	typedef struct packed {
		logic [COL_W-1:0]  out_column;
		logic              wall_found;
		logic              hit_side;
		logic [CELL_W-1:0] hit_cell_x;
		logic [CELL_W-1:0] hit_cell_y;
		logic [DIST_W-1:0] perp_distance;
		logic [LH_W-1:0]   slice_height;
		logic [ROW_W-1:0]  draw_start;
		logic [ROW_W-1:0]  draw_end;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RAY_MUL, ST_RAY_ADD, ST_DIVX_GO, ST_DIVX_WAIT,
		ST_DIVY_GO, ST_DIVY_WAIT, ST_SIDE, ST_STEP, ST_CHECK, ST_DIST,
		ST_LH_GO, ST_LH_WAIT, ST_ROWS, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_CLEAR, OP_LOAD, OP_RAY_MUL, OP_RAY_ADD, OP_DIV_GO, OP_DIV_WAIT,
		OP_SIDE, OP_STEP, OP_CHECK, OP_DIST, OP_ROWS, OP_OUT_LOAD
	} dp_op_t;

	typedef enum logic [1:0] {DIV_DX, DIV_DY, DIV_LH} div_sel_t;

	typedef struct packed {
		dp_op_t   op;
		div_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_done;
		logic out_of_grid;
		logic wall_hit;
		logic step_limit;
	} dp_status_t;

endpackage
`default_nettype wire

[sv/grid_dda_raycaster_unit.sv]
// channel | signals                          | payload
// in      | in_valid, in_ready               | in_item (map write or cast)
// out     | out_valid, out_ready             | out_item (one per cast)
// cfg     | cfg_we, cfg_index, cfg_data      | six 16-bit registers
//
// A cast does setup and hand-off, two divisions for the deltas through one shared
// bit-serial divider, one map read per grid step of the walk and, on a hit, the
// distance, one more division and the draw rows.
// After reset a clearing pass zeroes the map; in_ready is low.
// A finished result waits in the output register; map writes are still taken
// meanwhile, and a cast holds in its last state until the output is free.
`default_nettype none
module grid_dda_raycaster_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire gdr_pkg::in_item_t             in_item,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output gdr_pkg::out_item_t                 out_item,
	input  wire logic                          cfg_we,
	input  wire logic [gdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gdr_pkg::CFG_W-1:0]     cfg_data
);
	import gdr_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       accept;

	assign accept = in_valid && in_ready;

	gdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cast_go   (accept && in_item.opcode == OPC_CAST),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid)
	);

	gdr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.map_we    (accept && in_item.opcode == OPC_MAP_WRITE),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_item  (out_item)
	);
endmodule
`default_nettype wire

[sv/gdr_div.sv]
`default_nettype none
module gdr_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [gdr_pkg::DIV_NW-1:0] dividend,
	input  wire logic [gdr_pkg::DIV_DW-1:0] divisor,
	output logic                            done,
	output logic [gdr_pkg::DIV_NW-1:0]      quotient
);
	import gdr_pkg::*;

	logic              busy_q, done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] dvd_q;
	logic [DIV_DW-1:0] dvs_q, rem_q;
	logic [DIV_DW:0]   trial, diff;
	logic              fits;

	// restoring division, one quotient bit a cycle; divisor zero gives all ones
	assign trial = {rem_q, dvd_q[DIV_NW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			dvd_q <= {dvd_q[DIV_NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule
`default_nettype wire

[sv/gdr_datapath.sv]
`default_nettype none
module gdr_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gdr_pkg::dp_cmd_t              cmd,
	output gdr_pkg::dp_status_t                status,
	input  wire logic                          map_we,
	input  wire gdr_pkg::in_item_t             in_item,
	input  wire logic                          cfg_we,
	input  wire logic [gdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gdr_pkg::CFG_W-1:0]     cfg_data,
	output gdr_pkg::out_item_t                 out_item
);
	import gdr_pkg::*;

	logic [CFG_W-1:0]        px_q, py_q;
	logic signed [CFG_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q      <= '0;
			py_q      <= '0;
			dir_x_q   <= 16'sd16384;
			dir_y_q   <= '0;
			plane_x_q <= '0;
			plane_y_q <= 16'sd10813;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PLAYER_X: px_q      <= cfg_data;
				CFG_PLAYER_Y: py_q      <= cfg_data;
				CFG_DIR_X:    dir_x_q   <= cfg_data;
				CFG_DIR_Y:    dir_y_q   <= cfg_data;
				CFG_PLANE_X:  plane_x_q <= cfg_data;
				CFG_PLANE_Y:  plane_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// wall map
	logic              mem [MAP_CELLS];
	logic              mem_we, mem_wd, rd_q;
	logic [MAP_AW-1:0] mem_wa, rd_addr, clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.op == OP_CLEAR)
			clr_q <= clr_q + 1'b1;
	end

	always_comb begin
		mem_we = map_we || cmd.op == OP_CLEAR;
		mem_wa = (cmd.op == OP_CLEAR) ? clr_q : {in_item.cell_y, in_item.cell_x};
		mem_wd = (cmd.op == OP_CLEAR) ? 1'b0 : in_item.cell_is_wall;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_q <= mem[rd_addr];
	end

	// ray setup
	logic [COL_W-1:0]         col_q;
	logic [COL_W+14:0]        cam_num;
	logic signed [CFG_W:0]    cam;
	logic signed [PROD_W-1:0] prodx_q, prody_q, shx, shy;
	logic signed [RAY_W-1:0]  rx_q, ry_q;
	logic [RAY_W-1:0]         absx, absy;

	assign cam_num = {col_q, 15'b0} >> COL_SHIFT;
	assign cam     = $signed({2'b0, cam_num[14:0]}) - 17'sd16384;
	assign shx     = prodx_q >>> 14;
	assign shy     = prody_q >>> 14;
	assign absx    = rx_q[RAY_W-1] ? RAY_W'(-rx_q) : rx_q;
	assign absy    = ry_q[RAY_W-1] ? RAY_W'(-ry_q) : ry_q;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD)
			col_q <= in_item.screen_column;
		if (cmd.op == OP_RAY_MUL) begin
			prodx_q <= plane_x_q * cam;
			prody_q <= plane_y_q * cam;
		end
		if (cmd.op == OP_RAY_ADD) begin
			rx_q <= RAY_W'(dir_x_q) + shx[RAY_W-1:0];
			ry_q <= RAY_W'(dir_y_q) + shy[RAY_W-1:0];
		end
	end

	// shared divider
	logic              div_done;
	logic [DIV_NW-1:0] div_n, div_q;
	logic [DIV_DW-1:0] div_d;
	logic [DIST_W-1:0] dist_q;

	always_comb begin
		case (cmd.sel)
			DIV_DX:  begin div_n = DIV_NW'(1 << 24); div_d = DIV_DW'(absx); end
			DIV_DY:  begin div_n = DIV_NW'(1 << 24); div_d = DIV_DW'(absy); end
			default: begin
				div_n = DIV_NW'(SCREEN_HEIGHT * 1024);
				div_d = dist_q;
			end
		endcase
	end

	gdr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIV_GO),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	// grid walk
	logic [DIST_W-1:0]   dx_q, dy_q;
	logic [SD_W-1:0]     sdx_q, sdy_q;
	logic [POS_W-1:0]    mx_q, my_q, mx_nx, my_nx;
	logic [STEP_W-1:0]   steps_q;
	logic                side_q, found_q, take_x, oog;
	logic [FRAC_W:0]     fx, fy;
	logic [FRAC_W+DIST_W:0] px, py;
	logic [SD_W-1:0]     dsub;
	logic [LH_W-1:0]     lh_q;
	logic [ROW_W-1:0]    ds_q, de_q;
	logic [LH_W:0]       ds_w, de_w;

	assign fx = rx_q[RAY_W-1] ? {1'b0, px_q[FRAC_W-1:0]} : 11'd1024 - px_q[FRAC_W-1:0];
	assign fy = ry_q[RAY_W-1] ? {1'b0, py_q[FRAC_W-1:0]} : 11'd1024 - py_q[FRAC_W-1:0];
	assign px = fx * dx_q;
	assign py = fy * dy_q;

	// ties step the y axis
	assign take_x = sdx_q < sdy_q;
	assign mx_nx  = take_x ? mx_q + (rx_q[RAY_W-1] ? {POS_W{1'b1}} : POS_W'(1)) : mx_q;
	assign my_nx  = take_x ? my_q : my_q + (ry_q[RAY_W-1] ? {POS_W{1'b1}} : POS_W'(1));
	assign rd_addr = {my_nx[CELL_W-1:0], mx_nx[CELL_W-1:0]};
	// unsigned compare also catches a step below zero
	assign oog    = mx_q >= POS_W'(MAP_SIZE) || my_q >= POS_W'(MAP_SIZE);
	assign dsub   = side_q ? sdy_q - SD_W'(dy_q) : sdx_q - SD_W'(dx_q);

	always_comb begin
		ds_w = (lh_q < LH_W'(SCREEN_HEIGHT)) ? (LH_W+1)'((SCREEN_HEIGHT - lh_q) >> 1) : '0;
		de_w = {1'b0, lh_q} + ds_w;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DIV_WAIT && div_done) begin
			case (cmd.sel)
				DIV_DX:  dx_q <= (div_q > DIV_NW'(DIST_MAX)) ? DIST_MAX : div_q[DIST_W-1:0];
				DIV_DY:  dy_q <= (div_q > DIV_NW'(DIST_MAX)) ? DIST_MAX : div_q[DIST_W-1:0];
				default: lh_q <= (div_q > DIV_NW'(LH_MAX)) ? LH_MAX : div_q[LH_W-1:0];
			endcase
		end
		case (cmd.op)
			OP_LOAD: found_q <= 1'b0;
			OP_SIDE: begin
				sdx_q   <= SD_W'(px >> FRAC_W);
				sdy_q   <= SD_W'(py >> FRAC_W);
				mx_q    <= POS_W'(px_q[CFG_W-1:FRAC_W]);
				my_q    <= POS_W'(py_q[CFG_W-1:FRAC_W]);
				steps_q <= '0;
				side_q  <= 1'b0;
			end
			OP_STEP: begin
				mx_q    <= mx_nx;
				my_q    <= my_nx;
				side_q  <= !take_x;
				steps_q <= steps_q + 1'b1;
				if (take_x)
					sdx_q <= sdx_q + SD_W'(dx_q);
				else
					sdy_q <= sdy_q + SD_W'(dy_q);
			end
			OP_CHECK: found_q <= !oog && rd_q;
			OP_DIST:  dist_q  <= (dsub > SD_W'(DIST_MAX)) ? DIST_MAX : dsub[DIST_W-1:0];
			OP_ROWS: begin
				ds_q <= ds_w[ROW_W-1:0];
				de_q <= (de_w >= (LH_W+1)'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT - 1)
				                                          : de_w[ROW_W-1:0];
			end
			OP_OUT_LOAD: begin
				out_item.out_column    <= col_q;
				out_item.wall_found    <= found_q;
				out_item.hit_side      <= found_q & side_q;
				out_item.hit_cell_x    <= found_q ? mx_q[CELL_W-1:0] : '0;
				out_item.hit_cell_y    <= found_q ? my_q[CELL_W-1:0] : '0;
				out_item.perp_distance <= found_q ? dist_q : '0;
				out_item.slice_height  <= found_q ? lh_q : '0;
				out_item.draw_start    <= found_q ? ds_q : '0;
				out_item.draw_end      <= found_q ? de_q : '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		status.clr_done    = clr_q == MAP_AW'(MAP_CELLS - 1);
		status.div_done    = div_done;
		status.out_of_grid = oog;
		status.wall_hit    = rd_q;
		status.step_limit  = steps_q == STEP_W'(MAX_STEPS);
	end
endmodule
`default_nettype wire

[sv/gdr_ctrl.sv]
`default_nettype none
module gdr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cast_go,
	input  wire logic                out_ready,
	input  wire gdr_pkg::dp_status_t status,
	output gdr_pkg::dp_cmd_t         cmd,
	output logic                     in_ready,
	output logic                     out_valid
);
	import gdr_pkg::*;

	state_t state_q, state_nx;
	logic   out_valid_q, slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR:     if (status.clr_done) state_nx = ST_IDLE;
			ST_IDLE:      if (cast_go) state_nx = ST_RAY_MUL;
			ST_RAY_MUL:   state_nx = ST_RAY_ADD;
			ST_RAY_ADD:   state_nx = ST_DIVX_GO;
			ST_DIVX_GO:   state_nx = ST_DIVX_WAIT;
			ST_DIVX_WAIT: if (status.div_done) state_nx = ST_DIVY_GO;
			ST_DIVY_GO:   state_nx = ST_DIVY_WAIT;
			ST_DIVY_WAIT: if (status.div_done) state_nx = ST_SIDE;
			ST_SIDE:      state_nx = ST_STEP;
			ST_STEP:      state_nx = ST_CHECK;
			ST_CHECK: begin
				if (status.out_of_grid)
					state_nx = ST_DONE;
				else if (status.wall_hit)
					state_nx = ST_DIST;
				else if (status.step_limit)
					state_nx = ST_DONE;
				else
					state_nx = ST_STEP;
			end
			ST_DIST:      state_nx = ST_LH_GO;
			ST_LH_GO:     state_nx = ST_LH_WAIT;
			ST_LH_WAIT:   if (status.div_done) state_nx = ST_ROWS;
			ST_ROWS:      state_nx = ST_DONE;
			ST_DONE:      if (slot_free) state_nx = ST_IDLE;
			default:      state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.sel  = DIV_DX;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.op = OP_CLEAR;
			ST_IDLE: begin
				in_ready = 1'b1;
				if (cast_go) cmd.op = OP_LOAD;
			end
			ST_RAY_MUL:   cmd.op = OP_RAY_MUL;
			ST_RAY_ADD:   cmd.op = OP_RAY_ADD;
			ST_DIVX_GO:   cmd.op = OP_DIV_GO;
			ST_DIVX_WAIT: cmd.op = OP_DIV_WAIT;
			ST_DIVY_GO:   begin cmd.op = OP_DIV_GO;   cmd.sel = DIV_DY; end
			ST_DIVY_WAIT: begin cmd.op = OP_DIV_WAIT; cmd.sel = DIV_DY; end
			ST_SIDE:      cmd.op = OP_SIDE;
			ST_STEP:      cmd.op = OP_STEP;
			ST_CHECK:     cmd.op = OP_CHECK;
			ST_DIST:      cmd.op = OP_DIST;
			ST_LH_GO:     begin cmd.op = OP_DIV_GO;   cmd.sel = DIV_LH; end
			ST_LH_WAIT:   begin cmd.op = OP_DIV_WAIT; cmd.sel = DIV_LH; end
			ST_ROWS:      cmd.op = OP_ROWS;
			ST_DONE:      if (slot_free) cmd.op = OP_OUT_LOAD;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.op == OP_OUT_LOAD)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

[sv/gdr_checker.sv]
`default_nettype none
module gdr_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire gdr_pkg::in_item_t             in_item,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire gdr_pkg::out_item_t            out_item
);
	import gdr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item dropped or changed while stalled");

	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.opcode == OPC_CAST |=> !in_ready)
		else $error("new item taken while a cast is in flight");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.wall_found |->
			out_item.perp_distance == '0 && out_item.slice_height == '0 &&
			out_item.draw_start == '0 && out_item.draw_end == '0 &&
			!out_item.hit_side)
		else $error("miss result carries hit data");

	a_rows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.wall_found |->
			out_item.draw_end < ROW_W'(SCREEN_HEIGHT) &&
			out_item.draw_start <= out_item.draw_end)
		else $error("draw rows out of range");
endmodule

bind grid_dda_raycaster_unit gdr_checker u_gdr_checker (.*);
`default_nettype wire

[test/tb_grid_dda_raycaster_unit.sv]
`default_nettype none
module tb_grid_dda_raycaster_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import gdr_pkg::*;

	localparam int NO_PROGRESS_LIMIT = 20000;
	localparam int DRAIN_CYCLES      = 400;
	localparam int LONG_HOLD_CYCLES  = 300;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	in_item_t in_item;
	out_item_t out_item;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	grid_dda_raycaster_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	in_item_t pending_items[$];
	out_item_t expected_hits[$];
	logic [CFG_W-1:0] view_regs[6];
	bit wall_map[MAP_SIZE][MAP_SIZE];
	int mismatches, casts_seen, walls_seen, map_writes_seen, idle_cycles;
	bit calm, hold_req, hold_active;
	int send_gap, recv_gap, hold_count;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint ray_delta(longint r);
		longint m, d;
		if (r == 0) return longint'(DIST_MAX);
		m = r < 0 ? -r : r;
		d = (longint'(1) << 24) / m;
		return d > longint'(DIST_MAX) ? longint'(DIST_MAX) : d;
	endfunction

	function automatic out_item_t trace_ray(logic [COL_W-1:0] col);
		longint cam, rx, ry, mx, my, stx, sty, dx, dy, sdx, sdy, fx, fy;
		longint perp, lh, ds, de;
		int side;
		bit found;
		out_item_t r;
		cam = longint'(col) * 64 - 16384;
		rx = longint'($signed(view_regs[CFG_DIR_X]))
			+ ((longint'($signed(view_regs[CFG_PLANE_X])) * cam) >>> 14);
		ry = longint'($signed(view_regs[CFG_DIR_Y]))
			+ ((longint'($signed(view_regs[CFG_PLANE_Y])) * cam) >>> 14);
		mx = longint'(view_regs[CFG_PLAYER_X] >> 10);
		my = longint'(view_regs[CFG_PLAYER_Y] >> 10);
		fx = longint'(view_regs[CFG_PLAYER_X] & 16'h3ff);
		fy = longint'(view_regs[CFG_PLAYER_Y] & 16'h3ff);
		dx = ray_delta(rx);
		dy = ray_delta(ry);
		if (rx < 0) begin stx = -1; sdx = (fx * dx) >> 10; end
		else begin stx = 1; sdx = ((1024 - fx) * dx) >> 10; end
		if (ry < 0) begin sty = -1; sdy = (fy * dy) >> 10; end
		else begin sty = 1; sdy = ((1024 - fy) * dy) >> 10; end
		side = 0;
		found = 0;
		perp = 0; lh = 0; ds = 0; de = 0;
		for (int s = 0; s < MAX_STEPS; s++) begin
			// ties step the y axis
			if (sdx < sdy) begin sdx += dx; mx += stx; side = 0; end
			else begin sdy += dy; my += sty; side = 1; end
			if (mx < 0 || mx >= MAP_SIZE || my < 0 || my >= MAP_SIZE) break;
			if (wall_map[mx][my]) begin found = 1; break; end
		end
		if (found) begin
			perp = side == 0 ? sdx - dx : sdy - dy;
			if (perp > longint'(DIST_MAX)) perp = longint'(DIST_MAX);
			if (perp == 0) lh = 65535;
			else begin
				lh = (longint'(SCREEN_HEIGHT) * 1024) / perp;
				if (lh > 65535) lh = 65535;
			end
			ds = lh < SCREEN_HEIGHT ? (SCREEN_HEIGHT - lh) / 2 : 0;
			de = lh + ds;
			if (de >= SCREEN_HEIGHT) de = SCREEN_HEIGHT - 1;
		end else begin
			side = 0; mx = 0; my = 0;
		end
		r.out_column    = col;
		r.wall_found    = found;
		r.hit_side      = side[0];
		r.hit_cell_x    = mx[CELL_W-1:0];
		r.hit_cell_y    = my[CELL_W-1:0];
		r.perp_distance = perp[DIST_W-1:0];
		r.slice_height  = lh[LH_W-1:0];
		r.draw_start    = ds[ROW_W-1:0];
		r.draw_end      = de[ROW_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want, int col);
		$display("mismatch column %0d %s: got %0d expected %0d", col, field, got, want);
		mismatches++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				if (in_item.opcode == OPC_MAP_WRITE) begin
					wall_map[in_item.cell_x][in_item.cell_y] = in_item.cell_is_wall;
					map_writes_seen++;
				end else begin
					expected_hits.push_back(trace_ray(in_item.screen_column));
				end
			end
			if (in_valid && !in_ready) begin
				// hold
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(0, 4);
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				in_valid <= 1'b1;
				in_item <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver readiness
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
			hold_count <= 0;
			hold_active <= 1'b0;
		end else if (hold_req && !hold_active && hold_count == 0) begin
			hold_active <= 1'b1;
			hold_count <= LONG_HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_active) begin
			if (hold_count == 1) begin
				hold_active <= 1'b0;
				out_ready <= 1'b1;
			end else out_ready <= 1'b0;
			hold_count <= hold_count - 1;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ready <= recv_gap == 1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			recv_gap <= $urandom_range(1, 5);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("unexpected result", 1, 0, out_item.out_column);
			end else begin
				out_item_t e;
				e = expected_hits.pop_front();
				casts_seen++;
				if (e.wall_found) walls_seen++;
				if (out_item.out_column != e.out_column)
					report_mismatch("out_column", out_item.out_column, e.out_column, e.out_column);
				if (out_item.wall_found != e.wall_found)
					report_mismatch("wall_found", out_item.wall_found, e.wall_found, e.out_column);
				if (out_item.hit_side != e.hit_side)
					report_mismatch("hit_side", out_item.hit_side, e.hit_side, e.out_column);
				if (out_item.hit_cell_x != e.hit_cell_x)
					report_mismatch("hit_cell_x", out_item.hit_cell_x, e.hit_cell_x, e.out_column);
				if (out_item.hit_cell_y != e.hit_cell_y)
					report_mismatch("hit_cell_y", out_item.hit_cell_y, e.hit_cell_y, e.out_column);
				if (out_item.perp_distance != e.perp_distance)
					report_mismatch("perp_distance", out_item.perp_distance,
						e.perp_distance, e.out_column);
				if (out_item.slice_height != e.slice_height)
					report_mismatch("slice_height", out_item.slice_height,
						e.slice_height, e.out_column);
				if (out_item.draw_start != e.draw_start)
					report_mismatch("draw_start", out_item.draw_start, e.draw_start, e.out_column);
				if (out_item.draw_end != e.draw_end)
					report_mismatch("draw_end", out_item.draw_end, e.draw_end, e.out_column);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= NO_PROGRESS_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic set_view(cfg_idx_t idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		view_regs[idx] = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_camera(logic [15:0] px, logic [15:0] py, logic [15:0] dxv,
			logic [15:0] dyv, logic [15:0] plx, logic [15:0] ply);
		set_view(CFG_PLAYER_X, px);
		set_view(CFG_PLAYER_Y, py);
		set_view(CFG_DIR_X, dxv);
		set_view(CFG_DIR_Y, dyv);
		set_view(CFG_PLANE_X, plx);
		set_view(CFG_PLANE_Y, ply);
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_hits.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic queue_map(int x, int y, bit wall);
		in_item_t it;
		it = '0;
		it.opcode = OPC_MAP_WRITE;
		it.cell_x = CELL_W'(x);
		it.cell_y = CELL_W'(y);
		it.cell_is_wall = wall;
		it.screen_column = COL_W'($urandom);
		pending_items.push_back(it);
	endtask

	task automatic queue_cast(int col);
		in_item_t it;
		it = $bits(in_item_t)'($urandom);
		it.opcode = OPC_CAST;
		it.screen_column = COL_W'(col);
		pending_items.push_back(it);
	endtask

	// mostly casts, with walls scattered around the player's cell
	task automatic queue_random(int n);
		int cx, cy;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 3) begin
				if ($urandom_range(0, 3) == 0) begin
					queue_map($urandom_range(0, 63), $urandom_range(0, 63),
						1'($urandom_range(0, 1)));
				end else begin
					cx = (view_regs[CFG_PLAYER_X] >> 10) + $urandom_range(0, 16) - 8;
					cy = (view_regs[CFG_PLAYER_Y] >> 10) + $urandom_range(0, 16) - 8;
					queue_map(cx & 63, cy & 63, $urandom_range(0, 9) < 7);
				end
			end else begin
				queue_cast($urandom_range(0, 511));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 0;
		hold_req = 0;
		mismatches = 0;
		casts_seen = 0;
		walls_seen = 0;
		map_writes_seen = 0;
		idle_cycles = 0;
		view_regs[CFG_PLAYER_X] = 16'd0;
		view_regs[CFG_PLAYER_Y] = 16'd0;
		view_regs[CFG_DIR_X] = 16'd16384;
		view_regs[CFG_DIR_Y] = 16'd0;
		view_regs[CFG_PLANE_X] = 16'd0;
		view_regs[CFG_PLANE_Y] = 16'd10813;
		foreach (wall_map[x, y]) wall_map[x][y] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset view: empty map, the ray leaves the grid; middle column has a zero y
		queue_cast(0);
		queue_cast(256);
		queue_cast(511);
		queue_map(0, 0, 1);
		queue_map(63, 63, 1);
		queue_map(63, 0, 1);
		queue_cast(256);
		queue_map(63, 0, 0);
		queue_cast(256);
		wait_drained();

		// player on a grid line next to a wall: zero distance
		set_camera(16'd5120, 16'd5120, -16'sd16384, 16'd0, 16'd0, 16'd0);
		queue_map(4, 5, 1);
		queue_cast(0);
		queue_cast(511);
		// diagonal from a cell center: equal side distances
		wait_drained();
		set_camera(16'd10752, 16'd10752, 16'd16384, 16'd16384, 16'd0, 16'd0);
		queue_map(11, 11, 1);
		queue_map(12, 11, 1);
		queue_cast(100);
		// near diagonal across the whole grid, long walk
		wait_drained();
		set_camera(16'd512, 16'd512, 16'd16384, 16'd16000, 16'd0, 16'd0);
		queue_cast(256);
		queue_cast(300);
		wait_drained();
		// register extremes
		set_camera(16'hffff, 16'hffff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		queue_cast(0);
		queue_cast(511);
		queue_map(62, 62, 1);
		queue_cast(200);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			set_camera(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			if (ph == 2) hold_req = 1;
			if (ph == 7) calm = 1;
			queue_random(48);
			if (ph == 2) begin
				while (!hold_active) @(posedge clk);
				hold_req = 0;
			end
			wait_drained();
		end

		while (expected_hits.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d casts (%0d wall hits) and %0d map writes over 13 views",
			casts_seen, walls_seen, map_writes_seen);
		if (mismatches == 0 && expected_hits.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_hits.size());
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
`default_nettype wire
